// File: design/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants for the relay PID autotuner
// Word layouts, request/phase/direction codes, register indexes.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int CYCLE_LIMIT  = 64;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    localparam int TEMP_W     = 13;
    localparam int BAND_W     = 8;
    localparam int DRIVE_W    = 8;
    localparam int CYC_W      = 7;
    localparam int LB_W       = 9;
    localparam int TICK_W     = 10;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 32;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // divider operand widths
    localparam int NUM_W = 66;
    localparam int DEN_W = 64;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_HALT  = 2'd2;

    localparam logic [STAT_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [STAT_W-1:0] PH_RUN     = 3'd1;
    localparam logic [STAT_W-1:0] PH_STABLE  = 3'd2;
    localparam logic [STAT_W-1:0] PH_TIMEOUT = 3'd3;
    localparam logic [STAT_W-1:0] PH_ABORT   = 3'd4;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_MAX  = 2'd1;
    localparam logic [1:0] DIR_MIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXCYC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS  = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TEMP_W-1:0] temperature;
    } in_word_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] heater_drive;
        logic [STAT_W-1:0]  status;
        logic [CYC_W-1:0]   cycles_done;
        logic               gains_valid;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
    } out_word_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  amp;
        logic [DRIVE_W-1:0] drive;
        logic [TIME_W-1:0]  period;
    } gain_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } gain_res_t;

endpackage

// File: design/rpa_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_window: sample history and peak scan
// Circular buffer; compares a new sample against the last lb entries,
// one per cycle, then appends it.
// ----------------------------------------------------------------------------
module rpa_window import rpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  logic [TEMP_W-1:0] sample,
    input  logic [LB_W-1:0]   lb,
    output logic              done,
    output logic              is_max,
    output logic              is_min
);

    logic [TEMP_W-1:0] mem [WINDOW_DEPTH];
    logic [TEMP_W-1:0] rd_data_reg;
    logic [WIN_AW-1:0] wp_reg;
    logic [WIN_AW-1:0] rd_addr;
    logic [LB_W-1:0]   idx_reg;
    logic [LB_W-1:0]   lb_reg;
    logic [TEMP_W-1:0] t_reg;
    logic              busy_reg;
    logic              pend_reg;
    logic              done_reg;
    logic              max_reg;
    logic              min_reg;
    logic              rd_en;
    logic              fin;

    assign rd_en   = busy_reg && (idx_reg < lb_reg);
    assign fin     = busy_reg && !rd_en && !pend_reg;
    assign rd_addr = wp_reg - WIN_AW'(1) - WIN_AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (fin) begin
            mem[wp_reg] <= t_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            wp_reg   <= '0;
            idx_reg  <= '0;
            lb_reg   <= '0;
            t_reg    <= '0;
            max_reg  <= 1'b0;
            min_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                pend_reg <= 1'b0;
                idx_reg  <= '0;
                lb_reg   <= lb;
                t_reg    <= sample;
                max_reg  <= 1'b1;
                min_reg  <= 1'b1;
            end else if (busy_reg) begin
                pend_reg <= rd_en;
                if (rd_en) begin
                    idx_reg <= idx_reg + LB_W'(1);
                end
                if (pend_reg) begin
                    if (!(t_reg > rd_data_reg)) max_reg <= 1'b0;
                    if (!(t_reg < rd_data_reg)) min_reg <= 1'b0;
                end
                if (fin) begin
                    busy_reg <= 1'b0;
                    wp_reg   <= wp_reg + WIN_AW'(1);
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign is_max = max_reg;
    assign is_min = min_reg;

endmodule

// File: design/rpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_div: rounding, saturating restoring divider
// quot = floor(num/den + 1/2), clamped to all ones; one bit per cycle.
// ----------------------------------------------------------------------------
module rpa_div import rpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [GAIN_W-1:0] quot
);

    localparam int RW  = DEN_W + 1 + GAIN_W;
    localparam int CNT_W = $clog2(GAIN_W);

    logic [RW-1:0]     n2;
    logic [RW-1:0]     d2_top;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     ds_reg;
    logic [GAIN_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    // round half up: (2n + d) / 2d
    assign n2     = RW'({num, 1'b0}) + RW'(den);
    assign d2_top = {den, 1'b0, GAIN_W'(0)};
    assign ge     = rem_reg >= ds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            ds_reg   <= '0;
            q_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (n2 >= d2_top) begin
                    q_reg    <= '1;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= n2;
                    ds_reg   <= d2_top >> 1;
                    q_reg    <= '0;
                    cnt_reg  <= CNT_W'(GAIN_W - 1);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (ge) rem_reg <= rem_reg - ds_reg;
                q_reg  <= {q_reg[GAIN_W-2:0], ge};
                ds_reg <= ds_reg >> 1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: design/rpa_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_gain: Ziegler-Nichols gain sequencer
// One shared multiplier builds the operands, one divider gives Kp, Ki, Kd.
// ----------------------------------------------------------------------------
module rpa_gain import rpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  gain_req_t req,
    output logic      done,
    output gain_res_t res
);

    // Ku*pi*A = 128*D; Kp num 0.6*128*100000*2^16 = 1875 << 28 etc.
    localparam logic [31:0] PI_SCALED = 32'd314159;
    localparam logic [31:0] KP_COEF   = 32'd1875;
    localparam logic [31:0] KI_COEF   = 32'd1875000;
    localparam int KP_SHIFT = 28;
    localparam int KI_SHIFT = 29;
    localparam int KD_HI    = 26;
    localparam int KD_LO    = 22;

    localparam logic [1:0] SEL_P = 2'd0;
    localparam logic [1:0] SEL_I = 2'd1;
    localparam logic [1:0] SEL_D = 2'd2;

    typedef enum logic [7:0] {
        G_IDLE = 8'b00000001,
        G_DEN  = 8'b00000010,
        G_DENP = 8'b00000100,
        G_DP   = 8'b00001000,
        G_NP   = 8'b00010000,
        G_NI   = 8'b00100000,
        G_LOAD = 8'b01000000,
        G_WAIT = 8'b10000000
    } gstate_t;

    gstate_t            state_reg;
    logic [1:0]         sel_reg;
    logic               done_reg;
    logic [TEMP_W-1:0]  a_reg;
    logic [DRIVE_W-1:0] d_reg;
    logic [TIME_W-1:0]  p_reg;
    logic [31:0]        den_reg;
    logic [63:0]        denp_reg;
    logic [39:0]        dp_reg;
    logic [18:0]        np_reg;
    logic [28:0]        ni_reg;
    gain_res_t          res_reg;

    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [63:0]        prod;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [GAIN_W-1:0]  div_q;
    logic               skip_i;

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            G_DEN: begin
                mul_x = PI_SCALED;
                mul_y = 32'(a_reg);
            end
            G_DENP: begin
                mul_x = den_reg;
                mul_y = p_reg;
            end
            G_DP: begin
                mul_x = 32'(d_reg);
                mul_y = p_reg;
            end
            G_NP: begin
                mul_x = KP_COEF;
                mul_y = 32'(d_reg);
            end
            G_NI: begin
                mul_x = KI_COEF;
                mul_y = 32'(d_reg);
            end
            default: ;
        endcase
    end

    assign prod = mul_x * mul_y;

    always_comb begin
        case (sel_reg)
            SEL_P: begin
                div_num = NUM_W'({np_reg, KP_SHIFT'(0)});
                div_den = DEN_W'(den_reg);
            end
            SEL_I: begin
                div_num = NUM_W'({ni_reg, KI_SHIFT'(0)});
                div_den = denp_reg;
            end
            default: begin
                div_num = NUM_W'({dp_reg, KD_HI'(0)}) - NUM_W'({dp_reg, KD_LO'(0)});
                div_den = DEN_W'(den_reg);
            end
        endcase
    end

    // zero period: integral gain saturates
    assign skip_i    = (sel_reg == SEL_I) && (p_reg == '0);
    assign div_start = (state_reg == G_LOAD) && !skip_i;

    rpa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
            sel_reg   <= SEL_P;
            done_reg  <= 1'b0;
            a_reg     <= '0;
            d_reg     <= '0;
            p_reg     <= '0;
            den_reg   <= '0;
            denp_reg  <= '0;
            dp_reg    <= '0;
            np_reg    <= '0;
            ni_reg    <= '0;
            res_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                G_IDLE: begin
                    if (start) begin
                        a_reg   <= req.amp;
                        d_reg   <= req.drive;
                        p_reg   <= req.period;
                        sel_reg <= SEL_P;
                        if (req.amp == '0) begin
                            res_reg  <= '1;
                            done_reg <= 1'b1;
                        end else begin
                            state_reg <= G_DEN;
                        end
                    end
                end
                G_DEN: begin
                    den_reg   <= prod[31:0];
                    state_reg <= G_DENP;
                end
                G_DENP: begin
                    denp_reg  <= prod;
                    state_reg <= G_DP;
                end
                G_DP: begin
                    dp_reg    <= prod[39:0];
                    state_reg <= G_NP;
                end
                G_NP: begin
                    np_reg    <= prod[18:0];
                    state_reg <= G_NI;
                end
                G_NI: begin
                    ni_reg    <= prod[28:0];
                    state_reg <= G_LOAD;
                end
                G_LOAD: begin
                    if (skip_i) begin
                        res_reg.gain_i <= '1;
                        sel_reg        <= SEL_D;
                    end else begin
                        state_reg <= G_WAIT;
                    end
                end
                G_WAIT: begin
                    if (div_done) begin
                        case (sel_reg)
                            SEL_P: begin
                                res_reg.gain_p <= div_q;
                                sel_reg        <= SEL_I;
                                state_reg      <= G_LOAD;
                            end
                            SEL_I: begin
                                res_reg.gain_i <= div_q;
                                sel_reg        <= SEL_D;
                                state_reg      <= G_LOAD;
                            end
                            default: begin
                                res_reg.gain_d <= div_q;
                                state_reg      <= G_IDLE;
                                done_reg       <= 1'b1;
                            end
                        endcase
                    end
                end
                default: state_reg <= G_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: design/relay_pid_autotuner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_pid_autotuner_top: relay-feedback PID autotuner, Z-N gains
// Relay control, peak tracking and gain calculation on one request stream.
// ----------------------------------------------------------------------------
// Usage notes:
//  - s_ channel: one word per request (start, sample tick, halt). s_ready is
//    high only while the block is free; one word is worked on at a time.
//  - m_ channel: exactly one result word per request word, in order. The
//    result sits in an output register, so a new request may be taken while
//    the previous result waits for m_ready.
//  - cfg_ channel: register writes, always ready; write only while idle.
//  - Flow: start, halt, reserved words and ticks before the first
//    overshoot go straight to ST_OUT and the output register; the next
//    word is taken once ST_OUT returns to idle. A tick that scans the
//    history waits for the window scan of lookback entries (lookback
//    clamped to 1..256), read one per cycle from the window RAM.
//  - A tick that ends the run adds five passes of the shared
//    multiplier and up to three 32-step divisions in the shared divider,
//    each with a load and a hand-back state. A zero swing saturates at once.
//  - Reset returns registers to defaults and the tuner to idle. The
//    history RAM is not cleared; its scan results are only used once refilled.
//  - If m_ready stays low, the finished result waits and no further
//    request is accepted beyond the one already taken.
// ----------------------------------------------------------------------------
module relay_pid_autotuner_top import rpa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_SETTLE = 6'b000100,
        ST_GAIN   = 6'b001000,
        ST_OUT    = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    // configuration
    logic [TEMP_W-1:0]  target_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [LB_W-1:0]    lookback_reg;
    logic [CYC_W-1:0]   maxcyc_reg;
    logic [DRIVE_W-1:0] rdrive_reg;
    logic [TICK_W-1:0]  tickms_reg;

    // tuner state
    state_t             state_reg;
    logic [TEMP_W-1:0]  t_reg;
    logic [STAT_W-1:0]  phase_reg;
    logic [STAT_W-1:0]  how_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic [LB_W-1:0]    fill_reg;
    logic [TIME_W-1:0]  tick_reg;
    logic [1:0]         dir_reg;
    logic [CYC_W-1:0]   cc_reg;
    logic               seen_reg;
    logic [TEMP_W-1:0]  amax_reg;
    logic [TEMP_W-1:0]  amin_reg;
    logic [TIME_W-1:0]  lmax_reg;
    logic [TIME_W-1:0]  pmax_reg;
    logic [TEMP_W-1:0]  rp_reg [4];
    gain_res_t          gains_reg;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic               accept;
    logic [LB_W-1:0]    lb_eff;
    logic [CYC_W-1:0]   lim;
    logic [TIME_W-1:0]  tick_new;
    logic               above_hi;
    logic               below_lo;
    logic               win_go;
    logic               win_done;
    logic               win_max;
    logic               win_min;
    logic               gain_start;
    logic               gain_done;
    gain_req_t          gain_req;
    gain_res_t          gain_res;
    logic               out_load;

    // peak update
    logic [TEMP_W-1:0]  pk_amax;
    logic [TEMP_W-1:0]  pk_amin;
    logic [1:0]         pk_dir;
    logic [CYC_W-1:0]   pk_cc;
    logic               pk_changed;
    logic [TIME_W-1:0]  pk_lmax;
    logic [TIME_W-1:0]  pk_pmax;
    logic [TEMP_W-1:0]  pk_rp [4];

    // settling test
    logic [TEMP_W-1:0]  p1;
    logic [TEMP_W-1:0]  p2;
    logic [TEMP_W-1:0]  p3;
    logic [TEMP_W-1:0]  d12;
    logic [TEMP_W-1:0]  d23;
    logic [TEMP_W:0]    spread;
    logic [TEMP_W+4:0]  spread10;
    logic [TEMP_W-1:0]  amp;
    logic               settled;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    always_comb begin
        if (lookback_reg == '0) begin
            lb_eff = LB_W'(1);
        end else if (int'(lookback_reg) > WINDOW_DEPTH) begin
            lb_eff = LB_W'(WINDOW_DEPTH);
        end else begin
            lb_eff = lookback_reg;
        end
        if (maxcyc_reg < CYC_W'(8)) begin
            lim = CYC_W'(8);
        end else if (int'(maxcyc_reg) > CYCLE_LIMIT) begin
            lim = CYC_W'(CYCLE_LIMIT);
        end else begin
            lim = maxcyc_reg;
        end
    end

    // relay thresholds, one bit wider so target +/- band never wraps
    assign tick_new = tick_reg + TIME_W'(tickms_reg);
    assign above_hi = {1'b0, s_data.temperature} >
                      ({1'b0, target_reg} + (TEMP_W+1)'(band_reg));
    assign below_lo = ({1'b0, s_data.temperature} + (TEMP_W+1)'(band_reg)) <
                      {1'b0, target_reg};

    assign win_go = accept && (s_data.req_type == REQ_TICK) && (phase_reg == PH_RUN)
                    && !(cc_reg >= lim) && (seen_reg || above_hi);

    rpa_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (win_go),
        .sample  (s_data.temperature),
        .lb      (lb_eff),
        .done    (win_done),
        .is_max  (win_max),
        .is_min  (win_min)
    );

    always_comb begin
        pk_amax    = amax_reg;
        pk_amin    = amin_reg;
        pk_dir     = dir_reg;
        pk_cc      = cc_reg;
        pk_changed = 1'b0;
        pk_lmax    = lmax_reg;
        pk_pmax    = pmax_reg;
        pk_rp      = rp_reg;
        if (win_max) begin
            if (t_reg > amax_reg) pk_amax = t_reg;
            if (dir_reg == DIR_NONE) pk_dir = DIR_MAX;
            if (dir_reg == DIR_MIN) begin
                pk_dir     = DIR_MAX;
                pk_changed = 1'b1;
                pk_pmax    = lmax_reg;
            end
            pk_lmax = tick_reg;
            pk_rp[cc_reg[1:0]] = t_reg;
        end else if (win_min) begin
            if (t_reg < amin_reg) pk_amin = t_reg;
            if (dir_reg == DIR_NONE) pk_dir = DIR_MIN;
            if (dir_reg == DIR_MAX) begin
                pk_dir = DIR_MIN;
                if (int'(cc_reg) < CYCLE_LIMIT) pk_cc = cc_reg + CYC_W'(1);
                pk_changed = 1'b1;
            end
            if (pk_cc < lim) pk_rp[pk_cc[1:0]] = t_reg;
        end
    end

    // spread of the last three peaks against the swing
    assign p1       = rp_reg[cc_reg[1:0] - 2'd1];
    assign p2       = rp_reg[cc_reg[1:0] - 2'd2];
    assign p3       = rp_reg[cc_reg[1:0] - 2'd3];
    assign d12      = (p1 > p2) ? (p1 - p2) : (p2 - p1);
    assign d23      = (p2 > p3) ? (p2 - p3) : (p3 - p2);
    assign spread   = (TEMP_W+1)'(d12) + (TEMP_W+1)'(d23);
    assign spread10 = ((TEMP_W+5)'(spread) << 3) + ((TEMP_W+5)'(spread) << 1);
    assign amp      = amax_reg - amin_reg;
    assign settled  = spread10 < (TEMP_W+5)'(amp);

    assign gain_start = (accept && (s_data.req_type == REQ_TICK) && (phase_reg == PH_RUN)
                         && (cc_reg >= lim))
                        || ((state_reg == ST_SETTLE) && settled);
    assign gain_req.amp    = amp;
    assign gain_req.drive  = rdrive_reg;
    assign gain_req.period = lmax_reg - pmax_reg;

    rpa_gain u_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gain_start),
        .req     (gain_req),
        .done    (gain_done),
        .res     (gain_res)
    );

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TEMP_W'(3200);
            band_reg     <= BAND_W'(8);
            lookback_reg <= LB_W'(200);
            maxcyc_reg   <= CYC_W'(8);
            rdrive_reg   <= DRIVE_W'(255);
            tickms_reg   <= TICK_W'(50);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TARGET:   target_reg   <= cfg_data[TEMP_W-1:0];
                CFG_BAND:     band_reg     <= cfg_data[BAND_W-1:0];
                CFG_LOOKBACK: lookback_reg <= cfg_data[LB_W-1:0];
                CFG_MAXCYC:   maxcyc_reg   <= cfg_data[CYC_W-1:0];
                CFG_DRIVE:    rdrive_reg   <= cfg_data[DRIVE_W-1:0];
                CFG_TICK_MS:  tickms_reg   <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // request sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            phase_reg <= PH_IDLE;
            how_reg   <= PH_IDLE;
            drive_reg <= '0;
            fill_reg  <= '0;
            tick_reg  <= '0;
            dir_reg   <= DIR_NONE;
            cc_reg    <= '0;
            seen_reg  <= 1'b0;
            amax_reg  <= '0;
            amin_reg  <= '0;
            lmax_reg  <= '0;
            pmax_reg  <= '0;
            rp_reg    <= '{default: '0};
            gains_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        t_reg     <= s_data.temperature;
                        state_reg <= ST_OUT;
                        case (s_data.req_type)
                            REQ_START: begin
                                fill_reg  <= '0;
                                tick_reg  <= '0;
                                dir_reg   <= DIR_NONE;
                                cc_reg    <= '0;
                                seen_reg  <= 1'b0;
                                amax_reg  <= '0;
                                amin_reg  <= '0;
                                lmax_reg  <= '0;
                                pmax_reg  <= '0;
                                rp_reg    <= '{default: '0};
                                drive_reg <= '0;
                                phase_reg <= PH_RUN;
                                gains_reg <= '0;
                            end
                            REQ_TICK: begin
                                if (phase_reg == PH_RUN) begin
                                    tick_reg <= tick_new;
                                    if (cc_reg >= lim) begin
                                        // budget used: this sample is dropped
                                        how_reg   <= PH_TIMEOUT;
                                        state_reg <= ST_GAIN;
                                    end else begin
                                        if (above_hi) begin
                                            drive_reg <= '0;
                                            if (!seen_reg) begin
                                                seen_reg <= 1'b1;
                                                amax_reg <= s_data.temperature;
                                                amin_reg <= s_data.temperature;
                                            end
                                        end else if (below_lo) begin
                                            drive_reg <= rdrive_reg;
                                        end
                                        if (win_go) state_reg <= ST_SCAN;
                                    end
                                end
                            end
                            REQ_HALT: begin
                                if (phase_reg == PH_RUN) begin
                                    drive_reg <= '0;
                                    phase_reg <= PH_ABORT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (win_done) begin
                        if (fill_reg < lb_eff) begin
                            fill_reg  <= fill_reg + LB_W'(1);
                            state_reg <= ST_OUT;
                        end else begin
                            amax_reg <= pk_amax;
                            amin_reg <= pk_amin;
                            dir_reg  <= pk_dir;
                            cc_reg   <= pk_cc;
                            lmax_reg <= pk_lmax;
                            pmax_reg <= pk_pmax;
                            rp_reg   <= pk_rp;
                            if (pk_changed && (pk_cc >= CYC_W'(4))) begin
                                state_reg <= ST_SETTLE;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_SETTLE: begin
                    if (settled) begin
                        how_reg   <= PH_STABLE;
                        state_reg <= ST_GAIN;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_GAIN: begin
                    if (gain_done) begin
                        gains_reg <= gain_res;
                        phase_reg <= how_reg;
                        drive_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg             <= 1'b1;
                m_data_reg.heater_drive <= drive_reg;
                m_data_reg.status       <= phase_reg;
                m_data_reg.cycles_done  <= cc_reg;
                if ((phase_reg == PH_STABLE) || (phase_reg == PH_TIMEOUT)) begin
                    m_data_reg.gains_valid <= 1'b1;
                    m_data_reg.gain_p      <= gains_reg.gain_p;
                    m_data_reg.gain_i      <= gains_reg.gain_i;
                    m_data_reg.gain_d      <= gains_reg.gain_d;
                end else begin
                    m_data_reg.gains_valid <= 1'b0;
                    m_data_reg.gain_p      <= '0;
                    m_data_reg.gain_i      <= '0;
                    m_data_reg.gain_d      <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
